FILE: rtl/wst_pkg.sv
// Shared types and constants for the waypoint step unit.
package wst_pkg;

   localparam int COORD_WIDTH = 28;
   localparam int FRAC_BITS   = 16;
   localparam int LANES       = 3;
   localparam int REG_WIDTH   = COORD_WIDTH - 1;
   localparam int ROOT_WIDTH  = COORD_WIDTH + 1;
   localparam int SUM_WIDTH   = 2 * COORD_WIDTH + 2;
   localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
   localparam int REM_WIDTH   = ROOT_WIDTH + 3;
   localparam int PROD_WIDTH  = 2 * COORD_WIDTH - 1;
   localparam int DREM_WIDTH  = ROOT_WIDTH + 1;

   localparam logic [REG_WIDTH-1:0] STEP_RESET   = REG_WIDTH'(2 << FRAC_BITS);
   localparam logic [REG_WIDTH-1:0] RADIUS_RESET = REG_WIDTH'((2 << FRAC_BITS) / 10);

   typedef enum logic [0:0] {
      CSR_STEP_LENGTH   = 1'b0,
      CSR_ARRIVE_RADIUS = 1'b1
   } csr_index_type;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      coord_type pos_x;
      coord_type pos_y;
      coord_type pos_z;
      coord_type goal_x;
      coord_type goal_y;
      coord_type goal_z;
   } req_type;

   typedef struct packed {
      coord_type set_x;
      coord_type set_y;
      coord_type set_z;
      logic      arrived;
   } rsp_type;

   typedef struct packed {
      logic [LANES-1:0][COORD_WIDTH-1:0] pos;
      logic [LANES-1:0][COORD_WIDTH-1:0] goal;
      logic [LANES-1:0]                  neg;
      logic [LANES-1:0][COORD_WIDTH-1:0] mag;
   } root_tag_type;

   typedef struct packed {
      logic [LANES-1:0][COORD_WIDTH-1:0] pos;
      logic [LANES-1:0][COORD_WIDTH-1:0] goal;
      logic [LANES-1:0]                  neg;
      logic                              pass;
      logic                              arrived;
   } div_tag_type;

endpackage

FILE: rtl/wst_root_cell.sv
// One cell of the square root chain: settles one root bit per beat.
module wst_root_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [wst_pkg::SUM_WIDTH-1:0]  in_rad,
   input  logic [wst_pkg::REM_WIDTH-1:0]  in_rem,
   input  logic [wst_pkg::ROOT_WIDTH-1:0] in_root,
   input  wst_pkg::root_tag_type         in_tag,
   output logic                          out_valid,
   output logic [wst_pkg::SUM_WIDTH-1:0]  out_rad,
   output logic [wst_pkg::REM_WIDTH-1:0]  out_rem,
   output logic [wst_pkg::ROOT_WIDTH-1:0] out_root,
   output wst_pkg::root_tag_type         out_tag
);
   import wst_pkg::*;

   logic                  valid_ff;
   logic [SUM_WIDTH-1:0]  rad_ff, rad_in;
   logic [REM_WIDTH-1:0]  rem_ff, rem_in;
   logic [ROOT_WIDTH-1:0] root_ff, root_in;
   root_tag_type          tag_ff;
   logic [REM_WIDTH-1:0]  shifted;
   logic [REM_WIDTH-1:0]  trial;

   always_comb begin
      shifted = {in_rem[REM_WIDTH-3:0], in_rad[SUM_WIDTH-1 -: 2]};
      trial   = REM_WIDTH'({in_root, 2'b01});
      rad_in  = {in_rad[SUM_WIDTH-3:0], 2'b00};
      if (shifted >= trial) begin
         rem_in  = shifted - trial;
         root_in = {in_root[ROOT_WIDTH-2:0], 1'b1};
      end else begin
         rem_in  = shifted;
         root_in = {in_root[ROOT_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      tag_ff  <= in_tag;
   end

   assign out_valid = valid_ff;
   assign out_rad   = rad_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_tag   = tag_ff;

endmodule

FILE: rtl/wst_div_cell.sv
// One cell of the divider chain: settles one quotient bit per beat on all three axes.
module wst_div_cell (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 in_valid,
   input  logic [wst_pkg::ROOT_WIDTH-1:0]                        in_den,
   input  logic [wst_pkg::LANES-1:0][wst_pkg::DREM_WIDTH-1:0]    in_rem,
   input  logic [wst_pkg::LANES-1:0][wst_pkg::COORD_WIDTH-1:0]   in_num,
   input  logic [wst_pkg::LANES-1:0][wst_pkg::COORD_WIDTH-1:0]   in_quo,
   input  wst_pkg::div_tag_type                                 in_tag,
   output logic                                                 out_valid,
   output logic [wst_pkg::ROOT_WIDTH-1:0]                        out_den,
   output logic [wst_pkg::LANES-1:0][wst_pkg::DREM_WIDTH-1:0]    out_rem,
   output logic [wst_pkg::LANES-1:0][wst_pkg::COORD_WIDTH-1:0]   out_num,
   output logic [wst_pkg::LANES-1:0][wst_pkg::COORD_WIDTH-1:0]   out_quo,
   output wst_pkg::div_tag_type                                 out_tag
);
   import wst_pkg::*;

   logic                                valid_ff;
   logic [ROOT_WIDTH-1:0]               den_ff;
   logic [LANES-1:0][DREM_WIDTH-1:0]    rem_ff, rem_in;
   logic [LANES-1:0][COORD_WIDTH-1:0]   num_ff, num_in;
   logic [LANES-1:0][COORD_WIDTH-1:0]   quo_ff, quo_in;
   div_tag_type                         tag_ff;
   logic [LANES-1:0][DREM_WIDTH-1:0]    shifted;
   logic [DREM_WIDTH-1:0]               den_ext;

   always_comb begin
      den_ext = DREM_WIDTH'(in_den);
      for (int l = 0; l < LANES; l++) begin
         shifted[l] = {in_rem[l][DREM_WIDTH-2:0], in_num[l][COORD_WIDTH-1]};
         num_in[l]  = {in_num[l][COORD_WIDTH-2:0], 1'b0};
         if (shifted[l] >= den_ext) begin
            rem_in[l] = shifted[l] - den_ext;
            quo_in[l] = {in_quo[l][COORD_WIDTH-2:0], 1'b1};
         end else begin
            rem_in[l] = shifted[l];
            quo_in[l] = {in_quo[l][COORD_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      den_ff <= in_den;
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      tag_ff <= in_tag;
   end

   assign out_valid = valid_ff;
   assign out_den   = den_ff;
   assign out_rem   = rem_ff;
   assign out_num   = num_ff;
   assign out_quo   = quo_ff;
   assign out_tag   = tag_ff;

endmodule

FILE: rtl/waypoint_step_toward_target_3d_unit.sv
// Top level of the waypoint step unit: moves a 3-D position toward a target.
//
// Usage. A beat on the request side is taken at a clock edge where start is
// high and busy is low; busy is high while reset is high and until the first
// clock edge after reset is released. A new request may be given in every
// cycle. Each request yields exactly one response beat on rsp_valid/rsp_data,
// in request order, with rsp_valid high for one cycle; the receiver cannot
// stall the response side.
// Throughput is one request per cycle. From the request edge to the edge
// that takes the response, a request passes three entry stages (difference,
// squares, sum), a chain of 29 square root cells that each settle one root
// bit, one multiply stage, a chain of 28 divider cells that each settle one
// quotient bit on all three axes, and the output register.
// The csr channel writes step_length (index 0) and arrive_radius (index 1);
// csr_ready is always high. Write them only while no request is in flight.
// Reset clears the pipeline and loads step length 2.0 and radius 0.2.
module waypoint_step_toward_target_3d_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  wst_pkg::req_type               req_data,
   output logic                           rsp_valid,
   output wst_pkg::rsp_type               rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  wst_pkg::csr_index_type         csr_index,
   input  logic [wst_pkg::REG_WIDTH-1:0]  csr_data
);
   import wst_pkg::*;

   localparam int NDIV = COORD_WIDTH;

   logic                  busy_ff;
   logic [REG_WIDTH-1:0]  step_ff, radius_ff;
   logic                  accept;

   logic [LANES-1:0][COORD_WIDTH-1:0] in_pos, in_goal;
   logic signed [COORD_WIDTH:0]       diff [LANES];
   logic [COORD_WIDTH:0]              abs_diff [LANES];

   logic                              v1_ff;
   root_tag_type                      tag1_ff, tag1_in;
   logic                              v2_ff;
   root_tag_type                      tag2_ff;
   logic [LANES-1:0][SQ_WIDTH-1:0]    sq_ff, sq_in;
   logic                              v3_ff;
   root_tag_type                      tag3_ff;
   logic [SUM_WIDTH-1:0]              sum_ff, sum_in;

   logic                  root_valid [0:ROOT_WIDTH];
   logic [SUM_WIDTH-1:0]  root_rad   [0:ROOT_WIDTH];
   logic [REM_WIDTH-1:0]  root_rem   [0:ROOT_WIDTH];
   logic [ROOT_WIDTH-1:0] root_val   [0:ROOT_WIDTH];
   root_tag_type          root_tag   [0:ROOT_WIDTH];

   logic [ROOT_WIDTH-1:0]             root_dist;
   logic                              arrived_in, pass_in;
   logic                              m_valid_ff;
   logic [ROOT_WIDTH-1:0]             m_dist_ff;
   logic [LANES-1:0][PROD_WIDTH-1:0]  m_prod_ff, m_prod_in;
   div_tag_type                       m_tag_ff, m_tag_in;

   logic                                div_valid [0:NDIV];
   logic [ROOT_WIDTH-1:0]               div_den   [0:NDIV];
   logic [LANES-1:0][DREM_WIDTH-1:0]    div_rem   [0:NDIV];
   logic [LANES-1:0][COORD_WIDTH-1:0]   div_num   [0:NDIV];
   logic [LANES-1:0][COORD_WIDTH-1:0]   div_quo   [0:NDIV];
   div_tag_type                         div_tag   [0:NDIV];

   logic [LANES-1:0][COORD_WIDTH-1:0] next_pos;
   logic                              rsp_valid_ff;
   rsp_type                           rsp_data_ff, rsp_data_in;
   div_tag_type                       last_tag;

   assign accept    = start & ~busy_ff;
   assign busy      = busy_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         step_ff   <= STEP_RESET;
         radius_ff <= RADIUS_RESET;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid) begin
            unique case (csr_index)
               CSR_STEP_LENGTH:   step_ff   <= csr_data;
               CSR_ARRIVE_RADIUS: radius_ff <= csr_data;
            endcase
         end
      end
   end

   always_comb begin
      in_pos[0]  = req_data.pos_x;
      in_pos[1]  = req_data.pos_y;
      in_pos[2]  = req_data.pos_z;
      in_goal[0] = req_data.goal_x;
      in_goal[1] = req_data.goal_y;
      in_goal[2] = req_data.goal_z;
      for (int l = 0; l < LANES; l++) begin
         diff[l] = $signed({in_goal[l][COORD_WIDTH-1], in_goal[l]})
                 - $signed({in_pos[l][COORD_WIDTH-1], in_pos[l]});
         abs_diff[l]     = diff[l][COORD_WIDTH] ? -diff[l] : diff[l];
         tag1_in.pos[l]  = in_pos[l];
         tag1_in.goal[l] = in_goal[l];
         tag1_in.neg[l]  = diff[l][COORD_WIDTH];
         tag1_in.mag[l]  = abs_diff[l][COORD_WIDTH-1:0];
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         sq_in[l] = SQ_WIDTH'(tag1_ff.mag[l]) * SQ_WIDTH'(tag1_ff.mag[l]);
      end
      sum_in = SUM_WIDTH'(sq_ff[0]) + SUM_WIDTH'(sq_ff[1]) + SUM_WIDTH'(sq_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      tag1_ff <= tag1_in;
      tag2_ff <= tag1_ff;
      sq_ff   <= sq_in;
      tag3_ff <= tag2_ff;
      sum_ff  <= sum_in;
   end

   assign root_valid[0] = v3_ff;
   assign root_rad[0]   = sum_ff;
   assign root_rem[0]   = '0;
   assign root_val[0]   = '0;
   assign root_tag[0]   = tag3_ff;

   for (genvar i = 0; i < ROOT_WIDTH; i++) begin : g_root
      wst_root_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (root_valid[i]),
         .in_rad    (root_rad[i]),
         .in_rem    (root_rem[i]),
         .in_root   (root_val[i]),
         .in_tag    (root_tag[i]),
         .out_valid (root_valid[i+1]),
         .out_rad   (root_rad[i+1]),
         .out_rem   (root_rem[i+1]),
         .out_root  (root_val[i+1]),
         .out_tag   (root_tag[i+1])
      );
   end

   always_comb begin
      root_dist  = root_val[ROOT_WIDTH];
      arrived_in = root_dist < ROOT_WIDTH'(radius_ff);
      pass_in    = arrived_in || (root_dist < ROOT_WIDTH'(step_ff)) || (root_dist == '0);
      m_tag_in.pos     = root_tag[ROOT_WIDTH].pos;
      m_tag_in.goal    = root_tag[ROOT_WIDTH].goal;
      m_tag_in.neg     = root_tag[ROOT_WIDTH].neg;
      m_tag_in.pass    = pass_in;
      m_tag_in.arrived = arrived_in;
      for (int l = 0; l < LANES; l++) begin
         m_prod_in[l] = PROD_WIDTH'(root_tag[ROOT_WIDTH].mag[l]) * PROD_WIDTH'(step_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= root_valid[ROOT_WIDTH];
      end
      m_dist_ff <= root_dist;
      m_prod_ff <= m_prod_in;
      m_tag_ff  <= m_tag_in;
   end

   always_comb begin
      div_valid[0] = m_valid_ff;
      div_den[0]   = m_dist_ff;
      div_tag[0]   = m_tag_ff;
      for (int l = 0; l < LANES; l++) begin
         div_rem[0][l] = DREM_WIDTH'(m_prod_ff[l][PROD_WIDTH-1:COORD_WIDTH]);
         div_num[0][l] = m_prod_ff[l][COORD_WIDTH-1:0];
         div_quo[0][l] = '0;
      end
   end

   for (genvar i = 0; i < NDIV; i++) begin : g_div
      wst_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_den    (div_den[i]),
         .in_rem    (div_rem[i]),
         .in_num    (div_num[i]),
         .in_quo    (div_quo[i]),
         .in_tag    (div_tag[i]),
         .out_valid (div_valid[i+1]),
         .out_den   (div_den[i+1]),
         .out_rem   (div_rem[i+1]),
         .out_num   (div_num[i+1]),
         .out_quo   (div_quo[i+1]),
         .out_tag   (div_tag[i+1])
      );
   end

   always_comb begin
      last_tag = div_tag[NDIV];
      for (int l = 0; l < LANES; l++) begin
         if (last_tag.pass) begin
            next_pos[l] = last_tag.goal[l];
         end else if (last_tag.neg[l]) begin
            next_pos[l] = last_tag.pos[l] - div_quo[NDIV][l];
         end else begin
            next_pos[l] = last_tag.pos[l] + div_quo[NDIV][l];
         end
      end
      rsp_data_in.set_x   = next_pos[0];
      rsp_data_in.set_y   = next_pos[1];
      rsp_data_in.set_z   = next_pos[2];
      rsp_data_in.arrived = last_tag.arrived;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid[NDIV];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: verif/waypoint_step_checker.sv
// Checker that predicts and compares waypoint step results against the unit.
module waypoint_step_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  wst_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  wst_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  wst_pkg::csr_index_type        csr_index,
   input  logic [wst_pkg::REG_WIDTH-1:0] csr_data,
   output int                            error_count,
   output int                            pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import wst_pkg::*;

   logic [REG_WIDTH-1:0] step_reg;
   logic [REG_WIDTH-1:0] radius_reg;
   rsp_type              setpoint_queue[$];

   function automatic logic [63:0] floor_root(input logic [63:0] value);
      logic [63:0] root;
      logic [63:0] bitpos;
      logic [63:0] rest;
      root = 0;
      rest = value;
      bitpos = 64'd1 << 62;
      while (bitpos > rest) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (rest >= root + bitpos) begin
            rest = rest - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   function automatic rsp_type next_setpoint(input req_type item);
      rsp_type            result;
      logic signed [63:0] here[3];
      logic signed [63:0] delta[3];
      logic        [63:0] mag[3];
      logic        [63:0] sum;
      logic        [63:0] distance;
      logic        [63:0] move;
      logic signed [63:0] next[3];
      logic               reached;
      here[0] = 64'(signed'(item.pos_x));
      here[1] = 64'(signed'(item.pos_y));
      here[2] = 64'(signed'(item.pos_z));
      delta[0] = 64'(signed'(item.goal_x)) - here[0];
      delta[1] = 64'(signed'(item.goal_y)) - here[1];
      delta[2] = 64'(signed'(item.goal_z)) - here[2];
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = delta[i] < 0 ? -delta[i] : delta[i];
         sum = sum + mag[i] * mag[i];
      end
      distance = floor_root(sum);
      reached = distance < 64'(radius_reg);
      for (int i = 0; i < 3; i++) begin
         if (reached || distance < 64'(step_reg) || distance == 0) begin
            next[i] = here[i] + delta[i];
         end else begin
            move = (mag[i] * 64'(step_reg)) / distance;
            next[i] = delta[i] < 0 ? here[i] - signed'(move) : here[i] + signed'(move);
         end
      end
      result.set_x = next[0][COORD_WIDTH-1:0];
      result.set_y = next[1][COORD_WIDTH-1:0];
      result.set_z = next[2][COORD_WIDTH-1:0];
      result.arrived = reached;
      return result;
   endfunction

   assign pending_count = setpoint_queue.size();

   always @(posedge clock) begin
      rsp_type expected;
      if (reset) begin
         step_reg <= STEP_RESET;
         radius_reg <= RADIUS_RESET;
         error_count <= 0;
         setpoint_queue.delete();
      end else begin
         if (rsp_valid) begin
            if (setpoint_queue.size() == 0) begin
               if (error_count < 10) $display("unexpected result beat %p", rsp_data);
               error_count <= error_count + 1;
            end else begin
               expected = setpoint_queue.pop_front();
               if (rsp_data !== expected) begin
                  if (error_count < 10)
                     $display("mismatch: expected %p got %p", expected, rsp_data);
                  error_count <= error_count + 1;
               end
            end
         end
         if (start && !busy) setpoint_queue = {setpoint_queue, next_setpoint(req_data)};
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STEP_LENGTH: begin
                  step_reg <= csr_data;
               end
               CSR_ARRIVE_RADIUS: begin
                  radius_reg <= csr_data;
               end
               default: begin
               end
            endcase
         end
      end
   end
endmodule

FILE: verif/waypoint_step_toward_target_3d_unit_test.sv
// Stimulus and verdict for the waypoint step unit, with the checker beside it.
module waypoint_step_toward_target_3d_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import wst_pkg::*;

   localparam int LATENCY = 62;
   localparam int CYCLE_LIMIT = 200000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   csr_index_type        csr_index = CSR_STEP_LENGTH;
   logic [REG_WIDTH-1:0] csr_data = '0;
   int                   error_count;
   int                   pending_count;
   int                   cycle_count = 0;
   int                   idle_percent = 19;

   localparam coord_type CMAX = coord_type'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam coord_type CMIN = coord_type'({1'b1, {(COORD_WIDTH-1){1'b0}}});

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   waypoint_step_toward_target_3d_unit dut (.*);

   waypoint_step_checker checker_inst (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("waypoint_step_toward_target_3d_unit_test: errors");
         $finish;
      end
   end

   task automatic send_beat(input req_type item);
      while ($urandom_range(99) < idle_percent) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= item;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type index, input logic [REG_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      while (!csr_ready) @(negedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic req_type make_item(input int px, input int py, input int pz,
                                         input int gx, input int gy, input int gz);
      req_type item;
      item.pos_x = coord_type'(px);
      item.pos_y = coord_type'(py);
      item.pos_z = coord_type'(pz);
      item.goal_x = coord_type'(gx);
      item.goal_y = coord_type'(gy);
      item.goal_z = coord_type'(gz);
      return item;
   endfunction

   function automatic coord_type random_coord(input int spread);
      case ($urandom_range(3))
         0: return coord_type'($urandom);
         1: return coord_type'($signed($urandom_range(2 * spread)) - spread);
         2: return $urandom_range(1) ? CMAX : CMIN;
         default: return coord_type'($signed($urandom_range(8)) - 4);
      endcase
   endfunction

   function automatic req_type near_item(input int spread);
      req_type item;
      item.pos_x = random_coord(1 << 24);
      item.pos_y = random_coord(1 << 24);
      item.pos_z = random_coord(1 << 24);
      item.goal_x = item.pos_x + coord_type'($signed($urandom_range(2 * spread)) - spread);
      item.goal_y = item.pos_y + coord_type'($signed($urandom_range(2 * spread)) - spread);
      item.goal_z = item.pos_z + coord_type'($signed($urandom_range(2 * spread)) - spread);
      if ($urandom_range(3) == 0) begin
         item.goal_x = random_coord(1 << 26);
         item.goal_y = random_coord(1 << 26);
         item.goal_z = random_coord(1 << 26);
      end
      return item;
   endfunction

   initial begin
      req_type item;
      logic [REG_WIDTH-1:0] step_values[5];
      logic [REG_WIDTH-1:0] radius_values[5];
      step_values = '{REG_WIDTH'(0), {REG_WIDTH{1'b1}}, REG_WIDTH'(131072), REG_WIDTH'(1),
                      27'd3 << 16};
      radius_values = '{REG_WIDTH'(0), {REG_WIDTH{1'b1}}, REG_WIDTH'(13107), REG_WIDTH'(1),
                        27'd1 << 16};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      idle_percent = 0;
      send_beat('0);
      send_beat('{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
      send_beat('{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX});
      send_beat(make_item(0, 0, 0, 100, 0, 0));
      send_beat(make_item(0, 0, 0, 13106, 0, 0));
      send_beat(make_item(0, 0, 0, 13107, 0, 0));
      send_beat(make_item(0, 0, 0, 0, 131071, 0));
      send_beat(make_item(0, 0, 0, 0, 0, 131072));
      send_beat(make_item(5, -7, 9, -1000000, 2000000, -3000000));
      send_beat(make_item(-1, -1, -1, -1, -1, -1));
      drain();
      write_reg(CSR_STEP_LENGTH, '0);
      write_reg(CSR_ARRIVE_RADIUS, '0);
      send_beat('0);
      send_beat(make_item(0, 0, 0, 1, 0, 0));
      send_beat('{CMAX, coord_type'(0), CMIN, CMIN, coord_type'(0), CMAX});
      drain();

      for (int phase = 0; phase < 10; phase++) begin
         write_reg(CSR_STEP_LENGTH, step_values[phase % 5] ^
                   (phase >= 5 ? REG_WIDTH'($urandom_range(255)) : '0));
         write_reg(CSR_ARRIVE_RADIUS, radius_values[(phase + 2) % 5]);
         idle_percent = (phase == 3) ? 0 : 19;
         for (int n = 0; n < 120; n++) begin
            item = near_item(1 << (8 + $urandom_range(14)));
            send_beat(item);
            if (n == 60 && phase == 6) begin
               start <= 1'b0;
               @(negedge clock);
               while (pending_count != 0) @(negedge clock);
            end
         end
         drain();
      end

      if (error_count == 0) begin
         $display("waypoint_step_toward_target_3d_unit_test: clean");
      end else begin
         $display("waypoint_step_toward_target_3d_unit_test: errors");
      end
      $finish;
   end
endmodule

FILE: filelist.f
rtl/wst_pkg.sv
rtl/wst_root_cell.sv
rtl/wst_div_cell.sv
rtl/waypoint_step_toward_target_3d_unit.sv
verif/waypoint_step_checker.sv
verif/waypoint_step_toward_target_3d_unit_test.sv
